@@ hdl/adcg_pkg.sv @@
// ----------------------------------------------------------------------------
// adcg_pkg
// Shared types and constants for the airtime duty-cycle guard.
// ----------------------------------------------------------------------------
`default_nettype none

package adcg_pkg;

  localparam int unsigned RegW   = 27;
  localparam int unsigned NowW   = 32;
  localparam int unsigned AirW   = 16;
  localparam int unsigned UsedW  = 28;
  localparam int unsigned CountW = 13;
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;

  localparam logic [RegW-1:0]  WindowReset = 27'd3600000;
  localparam logic [RegW-1:0]  BudgetReset = 27'd36000;
  localparam logic [UsedW-1:0] UsedMax     = 28'hFFFFFFF;

  // Command codes carried by a beat.
  typedef enum logic {
    CMD_CHECK  = 1'b0,
    CMD_RECORD = 1'b1
  } cmd_e;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_BUDGET = 1'b1
  } reg_idx_e;

  // Sequencer state, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  // Status flags from the shared compare/accumulate unit.
  typedef struct packed {
    logic in_window;
    logic fits;
  } unit_res_t;

endpackage

`default_nettype wire

@@ hdl/airtime_duty_cycle_guard.sv @@
// ----------------------------------------------------------------------------
// airtime_duty_cycle_guard
// Sliding-window airtime limiter with a compacting record table.
// ----------------------------------------------------------------------------
// Record beat: result in the cycle after acceptance; busy stays low throughout.
// Check beat: busy is high while the held records are scanned, and the
//   result strobes in the first cycle after busy falls.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset: record count zero, window and budget at defaults; the table itself
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module airtime_duty_cycle_guard #(
  parameter int unsigned MAX_RECORDS = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Command channel.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cmd_i,
  input  wire logic [adcg_pkg::NowW-1:0]       now_ms_i,
  input  wire logic [adcg_pkg::AirW-1:0]       air_time_ms_i,
  // Result channel.
  output logic                                 result_valid_o,
  output logic                                 allowed_o,
  output logic      [adcg_pkg::UsedW-1:0]      used_ms_o,
  output logic                                 record_dropped_o,
  output logic      [adcg_pkg::CountW-1:0]     stored_count_o,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [adcg_pkg::PaddrW-1:0]     paddr,
  input  wire logic [adcg_pkg::PdataW-1:0]     pwdata,
  output logic      [adcg_pkg::PdataW-1:0]     prdata,
  output logic                                 pready
);

  // Count must hold MAX_RECORDS itself; the index need only reach MAX_RECORDS-1.
  localparam int unsigned CntW  = $clog2(MAX_RECORDS + 1);
  localparam int unsigned AddrW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned SumW  = adcg_pkg::AirW + CntW;
  localparam int unsigned DataW = adcg_pkg::NowW + adcg_pkg::AirW;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; the byte offset
  // bits of paddr are ignored.
  // --------------------------------------------------------------------------
  logic [adcg_pkg::RegW-1:0] window_q, budget_q;
  logic                      cfg_wr;
  adcg_pkg::reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = adcg_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= adcg_pkg::WindowReset;
      budget_q <= adcg_pkg::BudgetReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        adcg_pkg::REG_WINDOW: window_q <= pwdata[adcg_pkg::RegW-1:0];
        adcg_pkg::REG_BUDGET: budget_q <= pwdata[adcg_pkg::RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      adcg_pkg::REG_WINDOW: prdata = adcg_pkg::PdataW'(window_q);
      adcg_pkg::REG_BUDGET: prdata = adcg_pkg::PdataW'(budget_q);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state.
  // A check walks the table with a read pointer and a keep pointer. Each cycle
  // it issues one read and evaluates the entry read in the previous cycle.
  // Entries still inside the window are written back at the keep pointer,
  // which never passes the read pointer, so the table compacts in place.
  // --------------------------------------------------------------------------
  adcg_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  keep_q, keep_d;
  logic             vld_q, vld_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [adcg_pkg::NowW-1:0] now_q, now_d;
  logic [adcg_pkg::AirW-1:0] air_q, air_d;

  logic                     res_valid_q, res_valid_d;
  logic                     allowed_q, allowed_d;
  logic [adcg_pkg::UsedW-1:0]  used_q, used_d;
  logic                     dropped_q, dropped_d;
  logic [adcg_pkg::CountW-1:0] stored_q, stored_d;

  logic             accept;
  logic             rd_more;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [DataW-1:0] wr_data;
  logic             rd_en;
  logic [DataW-1:0] rd_data;

  logic [adcg_pkg::NowW-1:0] rd_stamp;
  logic [adcg_pkg::AirW-1:0] rd_air;
  logic [adcg_pkg::AirW-1:0] addend;
  logic [SumW-1:0]           sum_next;
  adcg_pkg::unit_res_t       unit_res;

  assign busy     = (state_q == adcg_pkg::ST_SCAN);
  assign accept   = start & ~busy;
  assign rd_more  = rd_idx_q < count_q;
  assign rd_stamp = rd_data[DataW-1:adcg_pkg::AirW];
  assign rd_air   = rd_data[adcg_pkg::AirW-1:0];
  // While an entry is in flight the adder accumulates it; on the final
  // cycle it adds the planned airtime for the budget compare.
  assign addend   = vld_q ? rd_air : air_q;

  adcg_store #(
    .Depth (MAX_RECORDS),
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  adcg_unit #(
    .SumW (SumW)
  ) u_unit (
    .now_i    (now_q),
    .stamp_i  (rd_stamp),
    .window_i (window_q),
    .budget_i (budget_q),
    .sum_i    (sum_q),
    .addend_i (addend),
    .sum_o    (sum_next),
    .res_o    (unit_res)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    keep_d      = keep_q;
    vld_d       = 1'b0;
    sum_d       = sum_q;
    now_d       = now_q;
    air_d       = air_q;
    res_valid_d = 1'b0;
    allowed_d   = allowed_q;
    used_d      = used_q;
    dropped_d   = dropped_q;
    stored_d    = stored_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[AddrW-1:0];
    wr_data     = {now_ms_i, air_time_ms_i};
    rd_en       = 1'b0;

    case (state_q)
      adcg_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_i == adcg_pkg::CMD_RECORD) begin
            // Record: append without purging, or flag a full table.
            res_valid_d = 1'b1;
            allowed_d   = 1'b0;
            used_d      = '0;
            if (count_q < CntW'(MAX_RECORDS)) begin
              wr_en     = 1'b1;
              count_d   = count_q + 1'b1;
              dropped_d = 1'b0;
              stored_d  = adcg_pkg::CountW'(count_q + 1'b1);
            end else begin
              dropped_d = 1'b1;
              stored_d  = adcg_pkg::CountW'(count_q);
            end
          end else begin
            now_d    = now_ms_i;
            air_d    = air_time_ms_i;
            rd_idx_d = '0;
            keep_d   = '0;
            sum_d    = '0;
            state_d  = adcg_pkg::ST_SCAN;
          end
        end
      end

      adcg_pkg::ST_SCAN: begin
        if (rd_more) begin
          rd_en    = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          vld_d    = 1'b1;
        end
        if (vld_q) begin
          if (unit_res.in_window) begin
            wr_en   = 1'b1;
            wr_addr = keep_q[AddrW-1:0];
            wr_data = rd_data;
            keep_d  = keep_q + 1'b1;
            sum_d   = sum_next;
          end
        end else if (!rd_more) begin
          // Pipeline drained: commit the new count and the verdict.
          count_d     = keep_q;
          res_valid_d = 1'b1;
          allowed_d   = unit_res.fits;
          dropped_d   = 1'b0;
          stored_d    = adcg_pkg::CountW'(keep_q);
          if (64'(sum_q) > 64'(adcg_pkg::UsedMax)) begin
            used_d = adcg_pkg::UsedMax;
          end else begin
            used_d = adcg_pkg::UsedW'(sum_q);
          end
          state_d = adcg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = adcg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adcg_pkg::ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      keep_q      <= '0;
      vld_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      keep_q      <= keep_d;
      vld_q       <= vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    now_q     <= now_d;
    air_q     <= air_d;
    allowed_q <= allowed_d;
    used_q    <= used_d;
    dropped_q <= dropped_d;
    stored_q  <= stored_d;
  end

  assign result_valid_o   = res_valid_q;
  assign allowed_o        = allowed_q;
  assign used_ms_o        = used_q;
  assign record_dropped_o = dropped_q;
  assign stored_count_o   = stored_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RECORDS))
    else $error("record count exceeds table depth");

  a_keep_behind_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (keep_q <= rd_idx_q) && (rd_idx_q <= count_q))
    else $error("scan pointers out of order");

  a_check_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == adcg_pkg::CMD_CHECK)) |=> busy && !result_valid_o)
    else $error("check beat did not start a scan");

  a_no_result_mid_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !result_valid_o)
    else $error("result strobed during a scan");

  a_record_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == adcg_pkg::CMD_RECORD)) |=>
      result_valid_o && !allowed_o && (used_ms_o == '0))
    else $error("record beat produced a wrong result");

endmodule

`default_nettype wire

@@ hdl/adcg_store.sv @@
// ----------------------------------------------------------------------------
// adcg_store
// Record table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module adcg_store #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12,
  parameter int unsigned DataW = 48
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/adcg_unit.sv @@
// ----------------------------------------------------------------------------
// adcg_unit
// Shared arithmetic unit: age check against the window, running-sum
// adder and budget compare.
// ----------------------------------------------------------------------------
`default_nettype none

module adcg_unit #(
  parameter int unsigned SumW = 29
) (
  input  wire logic [adcg_pkg::NowW-1:0] now_i,
  input  wire logic [adcg_pkg::NowW-1:0] stamp_i,
  input  wire logic [adcg_pkg::RegW-1:0] window_i,
  input  wire logic [adcg_pkg::RegW-1:0] budget_i,
  input  wire logic [SumW-1:0]           sum_i,
  input  wire logic [adcg_pkg::AirW-1:0] addend_i,
  output logic      [SumW-1:0]           sum_o,
  output adcg_pkg::unit_res_t            res_o
);

  localparam int unsigned CmpW = (SumW > adcg_pkg::RegW) ? SumW : adcg_pkg::RegW;

  logic [adcg_pkg::NowW-1:0] age;

  // Age wraps modulo 2^32, which plain unsigned subtraction gives.
  assign age             = now_i - stamp_i;
  assign res_o.in_window = age < {{(adcg_pkg::NowW - adcg_pkg::RegW){1'b0}}, window_i};
  assign sum_o           = sum_i + SumW'(addend_i);
  assign res_o.fits      = CmpW'(sum_o) <= CmpW'(budget_i);

endmodule

`default_nettype wire

@@ test/tb_airtime_duty_cycle_guard.sv @@
// ----------------------------------------------------------------------------
// tb_airtime_duty_cycle_guard
// Self-checking bench for the sliding-window airtime guard.
// ----------------------------------------------------------------------------
// Command beats go in on the start/busy handshake. A behavioral copy of the
// record table predicts every result beat, and a monitor compares each
// strobed result field by field with the oldest prediction. Directed tests
// cover the reset defaults, the budget boundary, timestamp wrap, a zero
// window and budget extremes. Random traffic follows under several window
// and budget settings. A watchdog ends a run that stalls.
// ----------------------------------------------------------------------------

module tb_airtime_duty_cycle_guard;

  localparam int unsigned MaxRecords  = 4096;
  // A check over a full table keeps the block quiet for its whole scan, so the
  // watchdog limit is set well above the length of that scan.
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned RandomBeats = 30;

  localparam logic [adcg_pkg::RegW-1:0] RegMax = '1;
  // Register bits above the 27 that the block keeps.
  localparam logic [adcg_pkg::PdataW-1:0] RegSpareMask = 32'hF800_0000;

  // One transmission as the table holds it.
  typedef struct {
    logic [adcg_pkg::NowW-1:0] stamp;
    logic [adcg_pkg::AirW-1:0] airtime;
  } flight_rec_t;

  // One result beat.
  typedef struct {
    logic                        allowed;
    logic [adcg_pkg::UsedW-1:0]  used;
    logic                        dropped;
    logic [adcg_pkg::CountW-1:0] count;
  } verdict_t;

  // Clock and reset. The clock starts low, so the first rising edge is at 5.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Command channel.
  logic                        start         = 1'b0;
  logic                        busy;
  logic                        cmd_i         = adcg_pkg::CMD_CHECK;
  logic [adcg_pkg::NowW-1:0]   now_ms_i      = '0;
  logic [adcg_pkg::AirW-1:0]   air_time_ms_i = '0;

  // Result channel.
  logic                        result_valid_o;
  logic                        allowed_o;
  logic [adcg_pkg::UsedW-1:0]  used_ms_o;
  logic                        record_dropped_o;
  logic [adcg_pkg::CountW-1:0] stored_count_o;

  // Configuration port. Only writes are issued.
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [adcg_pkg::PaddrW-1:0] paddr   = '0;
  logic [adcg_pkg::PdataW-1:0] pwdata  = '0;
  logic [adcg_pkg::PdataW-1:0] prdata;
  logic                        pready;

  // Behavioral copy of the block: its record table and its two registers.
  flight_rec_t               flight_log[$];
  logic [adcg_pkg::RegW-1:0] window_cfg = adcg_pkg::WindowReset;
  logic [adcg_pkg::RegW-1:0] budget_cfg = adcg_pkg::BudgetReset;

  // Results predicted at acceptance and not yet seen on the result ports.
  verdict_t verdict_q[$];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  // While set, the sender never idles between beats.
  bit          steady_mode    = 1'b0;
  // Running millisecond clock for the well-formed part of the random traffic.
  logic [adcg_pkg::NowW-1:0] sim_ms = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  airtime_duty_cycle_guard #(
    .MAX_RECORDS(MaxRecords)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .now_ms_i        (now_ms_i),
    .air_time_ms_i   (air_time_ms_i),
    .result_valid_o  (result_valid_o),
    .allowed_o       (allowed_o),
    .used_ms_o       (used_ms_o),
    .record_dropped_o(record_dropped_o),
    .stored_count_o  (stored_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Applies one command to the table copy and returns the result it causes.
  // A check drops every record whose age, taken modulo 2^32, is not below
  // the window, then sums what is left. The sum is kept wide so the budget
  // compare is exact. A record appends when there is room and never purges.
  function automatic verdict_t predict_verdict(input bit cmd,
                                               input logic [adcg_pkg::NowW-1:0] now,
                                               input logic [adcg_pkg::AirW-1:0] air);
    verdict_t                  v;
    flight_rec_t               kept[$];
    longint unsigned           sum;
    logic [adcg_pkg::NowW-1:0] age;
    v   = '{allowed: 1'b0, used: '0, dropped: 1'b0, count: '0};
    sum = 0;
    if (cmd == adcg_pkg::CMD_CHECK) begin
      foreach (flight_log[i]) begin
        age = now - flight_log[i].stamp;
        if (age < window_cfg) begin
          kept.push_back(flight_log[i]);
          sum += flight_log[i].airtime;
        end
      end
      flight_log = kept;
      v.allowed  = (sum + air <= budget_cfg);
      v.used     = (sum > adcg_pkg::UsedMax) ? adcg_pkg::UsedMax
                                             : sum[adcg_pkg::UsedW-1:0];
    end else if (flight_log.size() < MaxRecords) begin
      flight_log.push_back('{stamp: now, airtime: air});
    end else begin
      v.dropped = 1'b1;
    end
    v.count = adcg_pkg::CountW'(flight_log.size());
    return v;
  endfunction

  // Sends one command beat and records its prediction at the edge that
  // accepts it. Start is left high afterward: the next call either keeps it
  // high for a back-to-back beat or lowers it for an idle gap, so it is
  // never lowered and raised in the same step.
  task automatic send_beat(input bit cmd, input logic [adcg_pkg::NowW-1:0] now,
                           input logic [adcg_pkg::AirW-1:0] air);
    int unsigned gap;
    gap = 0;
    if (!steady_mode && $urandom_range(99) < 14) gap = 1;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_i         <= cmd;
    now_ms_i      <= now;
    air_time_ms_i <= air;
    // Busy is sampled as it was just before the edge, so a low value here
    // means this edge took the beat.
    do @(posedge clk_i); while (busy);
    verdict_q.push_back(predict_verdict(cmd, now, air));
  endtask

  // Lowers start and waits until every predicted result has been seen,
  // then waits on so the block is idle for a register write.
  task automatic drain_results();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Register write: a setup phase, then an access phase that ends at the
  // edge where the register takes the value. Only the low 27 bits
  // matter; callers may set the spare bits to show they are ignored.
  task automatic write_guard_reg(input adcg_pkg::reg_idx_e idx,
                                 input logic [adcg_pkg::PdataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      adcg_pkg::REG_WINDOW: window_cfg = value[adcg_pkg::RegW-1:0];
      adcg_pkg::REG_BUDGET: budget_cfg = value[adcg_pkg::RegW-1:0];
      default: ;
    endcase
  endtask

  // Reset values: an empty table, a one-hour window and a 36 s budget. The
  // budget test is inclusive, so a sum that lands exactly on it passes and
  // one millisecond more fails.
  task automatic test_reset_defaults();
    send_beat(adcg_pkg::CMD_CHECK, 32'd1000, 16'd0);
    send_beat(adcg_pkg::CMD_CHECK, 32'd1000, 16'hFFFF);
    send_beat(adcg_pkg::CMD_RECORD, 32'd1000, 16'd35000);
    send_beat(adcg_pkg::CMD_CHECK, 32'd2000, 16'd1000);
    send_beat(adcg_pkg::CMD_CHECK, 32'd2000, 16'd1001);
    drain_results();
  endtask

  // A 1000 ms window with records stamped around the 32-bit wrap. The
  // first check lands exactly one window after the earlier record, so that
  // record goes. Later checks after the wrap walk each record stamped before
  // the wrap across the edge of the window in turn.
  task automatic test_window_wrap();
    write_guard_reg(adcg_pkg::REG_WINDOW, RegSpareMask | 32'd1000);
    send_beat(adcg_pkg::CMD_CHECK, 32'd2000, 16'd0);
    send_beat(adcg_pkg::CMD_RECORD, 32'hFFFF_FE0C, 16'hFFFF);
    send_beat(adcg_pkg::CMD_RECORD, 32'hFFFF_FFFF, 16'd1);
    send_beat(adcg_pkg::CMD_RECORD, 32'd0, 16'd0);
    send_beat(adcg_pkg::CMD_CHECK, 32'd499, 16'd0);
    send_beat(adcg_pkg::CMD_CHECK, 32'd500, 16'd0);
    send_beat(adcg_pkg::CMD_CHECK, 32'd999, 16'd0);
    drain_results();
  endtask

  // With a zero window no age is below it, so one check empties the table.
  task automatic test_zero_window();
    send_beat(adcg_pkg::CMD_RECORD, 32'd100, 16'd500);
    send_beat(adcg_pkg::CMD_RECORD, 32'd200, 16'd700);
    drain_results();
    write_guard_reg(adcg_pkg::REG_WINDOW, 32'd0);
    send_beat(adcg_pkg::CMD_CHECK, 32'd200, 16'd0);
    drain_results();
    write_guard_reg(adcg_pkg::REG_WINDOW, 32'hFFFF_FFFF);
  endtask

  // A zero budget still grants a zero-length transmission on an empty
  // window; the largest budget grants the longest one on top of a record.
  task automatic test_budget_extremes();
    write_guard_reg(adcg_pkg::REG_BUDGET, 32'd0);
    send_beat(adcg_pkg::CMD_CHECK, 32'd300, 16'd0);
    send_beat(adcg_pkg::CMD_CHECK, 32'd300, 16'd1);
    send_beat(adcg_pkg::CMD_RECORD, 32'd300, 16'hFFFF);
    drain_results();
    write_guard_reg(adcg_pkg::REG_BUDGET, 32'hFFFF_FFFF);
    send_beat(adcg_pkg::CMD_CHECK, 32'd301, 16'hFFFF);
    drain_results();
  endtask

  // Random traffic in four settings. Most beats follow a running clock with
  // short steps, so records pile up inside the window and the budget is
  // reached; about a quarter carry a random time and airtime. The last
  // setting runs without any idle gap.
  task automatic test_random_traffic();
    logic [adcg_pkg::RegW-1:0] win_set;
    logic [adcg_pkg::RegW-1:0] bud_set;
    int unsigned               step_max;
    int unsigned               air_max;
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          win_set = 27'd5000;  bud_set = 27'd3000;  step_max = 800;    air_max = 600;
          sim_ms  = $urandom();
        end
        1: begin
          win_set = RegMax;    bud_set = RegMax;    step_max = 100000; air_max = 65535;
          sim_ms  = $urandom();
        end
        2: begin
          // Smallest window and an empty budget, started just short of the
          // wrap of the millisecond counter.
          win_set = 27'd1;     bud_set = 27'd0;     step_max = 1;      air_max = 2;
          sim_ms  = 32'hFFFF_FFF8;
        end
        default: begin
          win_set = 27'd60000; bud_set = 27'd20000; step_max = 5000;   air_max = 4000;
          sim_ms  = $urandom();
        end
      endcase
      write_guard_reg(adcg_pkg::REG_WINDOW, ($urandom() & RegSpareMask) | win_set);
      write_guard_reg(adcg_pkg::REG_BUDGET, ($urandom() & RegSpareMask) | bud_set);
      steady_mode = (phase == 3);
      repeat (RandomBeats) begin
        if ($urandom_range(3) == 0) begin
          send_beat(1'($urandom_range(1)), $urandom(),
                    adcg_pkg::AirW'($urandom_range(16'hFFFF)));
        end else begin
          sim_ms += $urandom_range(step_max);
          send_beat(1'($urandom_range(1)), sim_ms,
                    adcg_pkg::AirW'($urandom_range(air_max)));
        end
      end
    end
    steady_mode = 1'b0;
    drain_results();
  endtask

  // Result monitor. The receiver cannot stall, so every strobed cycle is a
  // beat that must match the oldest prediction.
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && result_valid_o) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("unexpected result beat: allowed=%0d used=%0d dropped=%0d count=%0d",
                   allowed_o, used_ms_o, record_dropped_o, stored_count_o);
        end
      end else begin
        want = verdict_q.pop_front();
        if (allowed_o !== want.allowed || used_ms_o !== want.used ||
            record_dropped_o !== want.dropped || stored_count_o !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("result mismatch: expected allowed=%0d used=%0d dropped=%0d count=%0d",
                     want.allowed, want.used, want.dropped, want.count);
            $display("                 actual   allowed=%0d used=%0d dropped=%0d count=%0d",
                     allowed_o, used_ms_o, record_dropped_o, stored_count_o);
          end
        end
      end
    end
  end

  // Watchdog: any accepted command or result beat restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("** airtime_duty_cycle_guard: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_window_wrap();
    test_zero_window();
    test_budget_extremes();
    test_random_traffic();

    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("** airtime_duty_cycle_guard: PASSED **");
    end else begin
      $display("** airtime_duty_cycle_guard: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/adcg_pkg.sv
hdl/adcg_store.sv
hdl/adcg_unit.sv
hdl/airtime_duty_cycle_guard.sv
test/tb_airtime_duty_cycle_guard.sv
